[hdl/ssc_pkg.sv]
// Shared types, codes and the commutation table for the six-step controller.
// No dependencies; used by every module under hdl/.
package ssc_pkg;

  localparam int unsigned CNT_W  = 19;   // tick counter width
  localparam int unsigned HOLD_W = 15;   // 50 + 65*255 fits in 15 bits

  localparam logic [7:0] CMD_NONE  = 8'h00;
  localparam logic [7:0] CMD_TIME  = 8'h54;  // 'T'
  localparam logic [7:0] CMD_STATE = 8'h53;  // 'S'
  localparam logic [7:0] RPL_ACK   = 8'h41;  // 'A'
  localparam logic [7:0] RPL_ERR   = 8'h45;  // 'E'
  localparam logic [7:0] RPL_NONE  = 8'h00;

  localparam logic [7:0] ST_OFF     = 8'd0;
  localparam logic [7:0] ST_STANDBY = 8'd1;
  localparam logic [7:0] ST_RUN     = 8'd2;

  localparam logic [2:0] LED_OFF     = 3'd1;
  localparam logic [2:0] LED_STANDBY = 3'd2;
  localparam logic [2:0] LED_RUN     = 3'd4;
  localparam logic [2:0] LED_FAULT   = 3'd5;

  localparam logic [7:0] STEP_TIME_RST = 8'd75;
  localparam logic [7:0] FIDELITY_RST  = 8'd3;
  localparam logic [2:0] LAST_STEP     = 3'd5;
  localparam logic [HOLD_W-1:0] HOLD_BASE  = 15'd50;
  localparam logic [6:0]        HOLD_SCALE = 7'd65;

  typedef enum logic [1:0] {
    ACT_IDLE  = 2'd0,
    ACT_BURST = 2'd1,
    ACT_BLINK = 2'd2
  } act_t;

  // command parser -> sequencer
  typedef struct packed {
    logic [7:0]        op_state;
    logic [HOLD_W-1:0] hold;
  } cmd_stat_t;

  // sequencer -> output stage
  typedef struct packed {
    act_t       act;
    logic [5:0] gates;
    logic       blink;
  } seq_stat_t;

  function automatic logic [5:0] step_gates(input logic [2:0] idx);
    logic [5:0] g;
    case (idx)
      3'd0:    g = 6'h09;
      3'd1:    g = 6'h21;
      3'd2:    g = 6'h24;
      3'd3:    g = 6'h06;
      3'd4:    g = 6'h12;
      3'd5:    g = 6'h18;
      default: g = 6'h00;
    endcase
    return g;
  endfunction

  function automatic logic [HOLD_W-1:0] hold_of(input logic [7:0] t);
    logic [HOLD_W-1:0] p;
    p = HOLD_W'(t) * HOLD_W'(HOLD_SCALE);
    return p + HOLD_BASE;
  endfunction

endpackage

[hdl/six_step_commutation_controller.sv]
// Six-step commutation controller, top level.
// Uses ssc_pkg, ssc_cmd and ssc_seq.
//
// Input stream: in_tuser[0] is the item kind (0 = one-microsecond tick,
// 1 = received serial byte), in_tdata carries the byte. Every item yields
// exactly one result on the output stream: gate pattern, mode LEDs,
// activity LED and an optional reply byte ('A' or 'E').
// Serial commands are two bytes: 'T' v sets the step time, 'S' v sets the
// operating state. In RUN each tick sampled between bursts starts a burst of
// fidelity+1 electrical cycles, each step held 50+65*step_time ticks.
// cfg_we/cfg_wdata write the fidelity count; write it only while idle.
// Path: an accepted item enters the input register, then the result register,
// which drives out_tvalid. Throughput: one item per cycle while out_tready
// stays high, set by the single update pass between the two registers.
// A full result register with out_tready low holds its item; one more item
// waits in the input register, after which in_tready drops.
// Reset (rst_n low, synchronous): state OFF, step time 75, fidelity 3,
// no command pending, gates off, both streams empty.
module six_step_commutation_controller #(
  parameter int unsigned BLINK_HALF_TICKS = 500000
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [5:0] phase_drive, [8:6] mode_leds,
                                  // [9] activity_led, [10] reply_valid,
                                  // [18:11] reply_byte, [23:19] zero
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata   // fidelity_count
);

  logic        in_v_r;
  logic        in_mode_r;
  logic [7:0]  in_byte_r;
  logic        proc_en;
  logic [7:0]  fid_r;
  logic        out_v_r;
  logic [23:0] out_d_r;

  ssc_pkg::cmd_stat_t cmd_cur, cmd_nxt;
  ssc_pkg::seq_stat_t seq_nxt;
  logic               rpl_v;
  logic [7:0]         rpl_b;
  logic [2:0]         leds;

  assign proc_en   = in_v_r && (!out_v_r || out_tready);
  assign in_tready = !in_v_r || proc_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      fid_r  <= ssc_pkg::FIDELITY_RST;
    end else begin
      if (in_tready) in_v_r <= in_tvalid;
      if (cfg_we) fid_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_mode_r <= in_tuser[0];
      in_byte_r <= in_tdata;
    end
  end

  ssc_cmd u_cmd (
    .clk         (clk),
    .rst_n       (rst_n),
    .byte_en     (proc_en && in_mode_r),
    .rx_byte     (in_byte_r),
    .stat_cur    (cmd_cur),
    .stat_nxt    (cmd_nxt),
    .reply_valid (rpl_v),
    .reply_byte  (rpl_b)
  );

  ssc_seq #(
    .BLINK_HALF_TICKS (BLINK_HALF_TICKS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick_en  (proc_en && !in_mode_r),
    .fidelity (fid_r),
    .cmd      (cmd_cur),
    .stat_nxt (seq_nxt)
  );

  always_comb begin
    case (seq_nxt.act)
      ssc_pkg::ACT_BURST: leds = ssc_pkg::LED_RUN;
      ssc_pkg::ACT_BLINK: leds = ssc_pkg::LED_STANDBY;
      default: begin
        if (cmd_nxt.op_state == ssc_pkg::ST_OFF) leds = ssc_pkg::LED_OFF;
        else if (cmd_nxt.op_state == ssc_pkg::ST_STANDBY) leds = ssc_pkg::LED_STANDBY;
        else if (cmd_nxt.op_state == ssc_pkg::ST_RUN) leds = ssc_pkg::LED_RUN;
        else leds = ssc_pkg::LED_FAULT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_en) begin
      out_d_r <= {5'd0, rpl_b, rpl_v, seq_nxt.blink, leds, seq_nxt.gates};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;

endmodule

[hdl/ssc_cmd.sv]
// Serial command parser: pending command, step time (kept as its hold count)
// and operating state, plus the reply byte. Depends on ssc_pkg.
module ssc_cmd (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_en,     // a serial item is processed
  input  logic [7:0]            rx_byte,
  output ssc_pkg::cmd_stat_t    stat_cur,    // before this item
  output ssc_pkg::cmd_stat_t    stat_nxt,    // after this item
  output logic                  reply_valid,
  output logic [7:0]            reply_byte
);

  logic [7:0]                 pend_r, pend_nxt;
  logic [7:0]                 op_r, op_nxt;
  logic [ssc_pkg::HOLD_W-1:0] hold_r, hold_nxt;

  always_comb begin
    pend_nxt    = pend_r;
    op_nxt      = op_r;
    hold_nxt    = hold_r;
    reply_valid = 1'b0;
    reply_byte  = ssc_pkg::RPL_NONE;
    if (byte_en) begin
      if (pend_r == ssc_pkg::CMD_NONE) begin
        pend_nxt = rx_byte;
      end else begin
        reply_valid = 1'b1;
        pend_nxt    = ssc_pkg::CMD_NONE;
        if (pend_r == ssc_pkg::CMD_TIME) begin
          hold_nxt   = ssc_pkg::hold_of(rx_byte);
          reply_byte = ssc_pkg::RPL_ACK;
        end else if (pend_r == ssc_pkg::CMD_STATE) begin
          op_nxt     = rx_byte;
          reply_byte = ssc_pkg::RPL_ACK;
        end else begin
          reply_byte = ssc_pkg::RPL_ERR;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= ssc_pkg::CMD_NONE;
      op_r   <= ssc_pkg::ST_OFF;
      hold_r <= ssc_pkg::hold_of(ssc_pkg::STEP_TIME_RST);
    end else begin
      pend_r <= pend_nxt;
      op_r   <= op_nxt;
      hold_r <= hold_nxt;
    end
  end

  assign stat_cur.op_state = op_r;
  assign stat_cur.hold     = hold_r;
  assign stat_nxt.op_state = op_nxt;
  assign stat_nxt.hold     = hold_nxt;

endmodule

[hdl/ssc_seq.sv]
// Tick sequencer: burst of six-step cycles, standby blink, gate pattern.
// Depends on ssc_pkg; takes operating state and hold count from ssc_cmd.
module ssc_seq #(
  parameter int unsigned BLINK_HALF_TICKS = 500000
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tick_en,    // a tick item is processed
  input  logic [7:0]          fidelity,
  input  ssc_pkg::cmd_stat_t  cmd,
  output ssc_pkg::seq_stat_t  stat_nxt
);

  localparam logic [ssc_pkg::CNT_W-1:0] BLINK_LIM = ssc_pkg::CNT_W'(BLINK_HALF_TICKS);

  ssc_pkg::act_t               act_r, act_nxt;
  logic [2:0]                  step_r, step_nxt;
  logic [7:0]                  cyc_r, cyc_nxt;
  logic [ssc_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [5:0]                  gate_r, gate_nxt;
  logic                        blink_r, blink_nxt;

  always_comb begin
    logic [ssc_pkg::CNT_W-1:0] cnt_inc;
    logic                      go;
    act_nxt   = act_r;
    step_nxt  = step_r;
    cyc_nxt   = cyc_r;
    cnt_nxt   = cnt_r;
    gate_nxt  = gate_r;
    blink_nxt = blink_r;
    go        = tick_en;
    // the sampling tick also counts as the first tick of what it starts
    if (tick_en && act_r == ssc_pkg::ACT_IDLE) begin
      if (cmd.op_state == ssc_pkg::ST_RUN) begin
        act_nxt  = ssc_pkg::ACT_BURST;
        step_nxt = 3'd0;
        cyc_nxt  = fidelity;
        cnt_nxt  = '0;
        gate_nxt = ssc_pkg::step_gates(3'd0);
      end else if (cmd.op_state == ssc_pkg::ST_STANDBY) begin
        act_nxt   = ssc_pkg::ACT_BLINK;
        cnt_nxt   = '0;
        blink_nxt = 1'b1;
      end else begin
        go = 1'b0;
      end
    end
    cnt_inc = cnt_nxt + 1'b1;
    if (go) begin
      case (act_nxt)
        ssc_pkg::ACT_BURST: begin
          if (cnt_inc >= ssc_pkg::CNT_W'(cmd.hold)) begin
            cnt_nxt = '0;
            if (step_nxt >= ssc_pkg::LAST_STEP) begin
              if (cyc_nxt == 8'd0) begin
                act_nxt = ssc_pkg::ACT_IDLE;
              end else begin
                cyc_nxt  = cyc_nxt - 8'd1;
                step_nxt = 3'd0;
                gate_nxt = ssc_pkg::step_gates(3'd0);
              end
            end else begin
              step_nxt = step_nxt + 3'd1;
              gate_nxt = ssc_pkg::step_gates(step_nxt);
            end
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        ssc_pkg::ACT_BLINK: begin
          if (cnt_inc >= BLINK_LIM) begin
            cnt_nxt = '0;
            if (blink_nxt) blink_nxt = 1'b0;
            else act_nxt = ssc_pkg::ACT_IDLE;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        default: begin
          cnt_nxt = cnt_inc;
          act_nxt = ssc_pkg::ACT_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= ssc_pkg::ACT_IDLE;
      step_r  <= 3'd0;
      cyc_r   <= 8'd0;
      cnt_r   <= '0;
      gate_r  <= 6'd0;
      blink_r <= 1'b0;
    end else begin
      act_r   <= act_nxt;
      step_r  <= step_nxt;
      cyc_r   <= cyc_nxt;
      cnt_r   <= cnt_nxt;
      gate_r  <= gate_nxt;
      blink_r <= blink_nxt;
    end
  end

  assign stat_nxt.act   = act_nxt;
  assign stat_nxt.gates = gate_nxt;
  assign stat_nxt.blink = blink_nxt;

endmodule

[hdl/ssc_chk.sv]
// Port-level checker for the six-step controller, bound to the top level.
// Depends on ssc_pkg for reply codes.
module ssc_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // no reply flag means a zero reply byte
  a_reply_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[10] |-> out_tdata[18:11] == ssc_pkg::RPL_NONE)
    else $error("reply byte set without reply flag");

  a_reply_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |->
      (out_tdata[18:11] == ssc_pkg::RPL_ACK || out_tdata[18:11] == ssc_pkg::RPL_ERR))
    else $error("bad reply code");

  a_leds_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[8:6] != 3'd0)
    else $error("no mode LED lit");

  // an empty result register never backs up the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled item changed");

endmodule

bind six_step_commutation_controller ssc_chk u_ssc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
